/* rtl/ibst_pkg.sv */
// Shared constants, codes and types for the array binary search tree.
package ibst_pkg;

   localparam int SLOTS  = 64;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int IDX_W  = $clog2(2 * SLOTS + 1);
   localparam int KEY_W  = 32;
   localparam int FN_W   = 2;
   localparam int ST_W   = 3;

   localparam logic [FN_W-1:0] FN_INSERT = 2'd0;
   localparam logic [FN_W-1:0] FN_PRE    = 2'd1;
   localparam logic [FN_W-1:0] FN_IN     = 2'd2;
   localparam logic [FN_W-1:0] FN_POST   = 2'd3;

   localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [ST_W-1:0] ST_ZERO     = 3'd1;
   localparam logic [ST_W-1:0] ST_DUP      = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
   localparam logic [ST_W-1:0] ST_VISIT    = 3'd4;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

   typedef struct packed {
      logic             key_less;
      logic             key_equal;
      logic             in_range;
      logic             is_root;
      logic             from_left;
      logic [IDX_W-1:0] left_idx;
      logic [IDX_W-1:0] right_idx;
      logic [IDX_W-1:0] parent_idx;
   } step_type;

endpackage

/* rtl/ibst_store.sv */
// Node store: slot memory with per-slot occupancy bits cleared at reset.
module ibst_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [ibst_pkg::ADDR_W-1:0] wr_addr,
   input  logic [ibst_pkg::KEY_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [ibst_pkg::ADDR_W-1:0] rd_addr,
   output logic [ibst_pkg::KEY_W-1:0]  rd_data,
   input  logic [ibst_pkg::ADDR_W-1:0] probe_addr,
   output logic                        probe_hit
);
   import ibst_pkg::*;

   logic [KEY_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] valid_in;
   logic [KEY_W-1:0] rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // a slot never written reads as empty
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data   = rd_data_ff;
   assign probe_hit = valid_ff[probe_addr];

endmodule

/* rtl/ibst_step_unit.sv */
// Shared step unit: signed key compare and implicit-tree index arithmetic.
module ibst_step_unit (
   input  logic [ibst_pkg::IDX_W-1:0]        idx,
   input  logic signed [ibst_pkg::KEY_W-1:0] key,
   input  logic signed [ibst_pkg::KEY_W-1:0] node,
   output ibst_pkg::step_type                step
);
   import ibst_pkg::*;

   always_comb begin
      step.key_less   = key < node;
      step.key_equal  = key == node;
      step.in_range   = idx < IDX_W'(SLOTS);
      step.is_root    = idx == '0;
      // left children sit at odd indexes
      step.from_left  = idx[0];
      step.left_idx   = IDX_W'({idx, 1'b0}) + IDX_W'(1);
      step.right_idx  = IDX_W'({idx, 1'b0}) + IDX_W'(2);
      step.parent_idx = (idx - IDX_W'(1)) >> 1;
   end

endmodule

/* rtl/implicit_bst_insert_traverse_core.sv */
// Top level: command sequencer for insert and tree dumps over the node store.
//
// Binary search tree in a 64-slot implicit array (children of p at 2p+1, 2p+2).
// An item is taken when start is high and busy is low; busy stays high until
// its last result has been issued. Each result is shown for one cycle with
// rsp_valid and must be taken then: the receiver cannot hold results off.
// An insert walks down one occupied level at a time, probing then comparing (a
// zero key answers the cycle after acceptance without raising busy); a dump
// visits every stored node. Inserts and dumps share the one step unit and the
// single read port of the node store, one tree step per cycle.
// The store is empty right after reset; no clearing pass is needed.
module implicit_bst_insert_traverse_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ibst_pkg::FN_W-1:0]          req_func,
   input  logic signed [ibst_pkg::KEY_W-1:0]  req_key_value,
   output logic                               rsp_valid,
   output logic signed [ibst_pkg::KEY_W-1:0]  rsp_out_value,
   output logic [ibst_pkg::ST_W-1:0]          rsp_status,
   output logic                               rsp_last
);
   import ibst_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PROBE  = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_DOWN   = 3'd3;
   localparam logic [2:0] S_UPL    = 3'd4;
   localparam logic [2:0] S_UPR    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [FN_W-1:0]   order_ff, order_in;
   logic              emit_q_ff, emit_q_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [KEY_W-1:0]  pend_value_ff, pend_value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic              rd_en;
   logic [KEY_W-1:0]  rd_data;
   logic              probe_hit;
   logic              present;
   step_type          step;

   ibst_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (idx_ff[ADDR_W-1:0]),
      .wr_data    (key_ff),
      .rd_en      (rd_en),
      .rd_addr    (idx_ff[ADDR_W-1:0]),
      .rd_data    (rd_data),
      .probe_addr (idx_ff[ADDR_W-1:0]),
      .probe_hit  (probe_hit)
   );

   ibst_step_unit u_step (
      .idx  (idx_ff),
      .key  (key_ff),
      .node (rd_data),
      .step (step)
   );

   assign present = step.in_range && probe_hit;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      order_in      = order_ff;
      emit_q_in     = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      // dump values arrive in the cycle after their read; hold one back for last
      if (emit_q_ff) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = pend_value_ff;
            rsp_status_in = ST_VISIT;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_value_in = rd_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in        = req_key_value;
               order_in      = req_func;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               if (req_func != FN_INSERT) begin
                  state_in = S_DOWN;
               end else if (req_key_value == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = ST_ZERO;
                  rsp_last_in   = 1'b1;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (!step.in_range) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = key_ff;
               rsp_status_in = ST_FULL;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else if (!probe_hit) begin
               wr_en         = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = key_ff;
               rsp_status_in = ST_INSERTED;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (step.key_equal) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = key_ff;
               rsp_status_in = ST_DUP;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               idx_in   = step.key_less ? step.left_idx : step.right_idx;
               state_in = S_PROBE;
            end
         end
         S_DOWN: begin
            if (present) begin
               rd_en     = order_ff == FN_PRE;
               emit_q_in = order_ff == FN_PRE;
               idx_in    = step.left_idx;
            end else if (step.is_root) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = step.parent_idx;
               state_in = step.from_left ? S_UPL : S_UPR;
            end
         end
         S_UPL: begin
            rd_en     = order_ff == FN_IN;
            emit_q_in = order_ff == FN_IN;
            idx_in    = step.right_idx;
            state_in  = S_DOWN;
         end
         S_UPR: begin
            rd_en     = order_ff == FN_POST;
            emit_q_in = order_ff == FN_POST;
            if (step.is_root) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = step.parent_idx;
               state_in = step.from_left ? S_UPL : S_UPR;
            end
         end
         S_FINISH: begin
            if (!emit_q_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_valid_ff ? pend_value_ff : '0;
               rsp_status_in = pend_valid_ff ? ST_VISIT : ST_EMPTY;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         emit_q_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         emit_q_ff     <= emit_q_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      order_ff      <= order_in;
      pend_value_ff <= pend_value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_insert_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_INSERTED || rsp_status == ST_ZERO ||
                    rsp_status == ST_DUP || rsp_status == ST_FULL) |-> rsp_last)
      else $error("insert result without last");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_last && rsp_out_value == '0)
      else $error("empty result malformed");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !emit_q_ff)
      else $error("dump read outstanding while idle");

   a_cmp_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> $past(state_ff) == S_PROBE)
      else $error("compare step without a probe");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && !emit_q_ff |=> rsp_valid && rsp_last && !busy)
      else $error("dump ended without a last result");
`endif

endmodule
